// ===== rtl/core/bmi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmi_pkg;

   localparam int FIELD_W  = 64;
   localparam int STATUS_W = 2;
   localparam int PC_W     = 4;
   localparam int OP_W     = 3;
   localparam int COND_W   = 4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EVEN_MOD = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_VAL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_INV   = 2'd3;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NOP      = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
   localparam logic [OP_W-1:0] OP_DIV_INIT = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd3;
   localparam logic [OP_W-1:0] OP_EUC_INIT = 3'd4;
   localparam logic [OP_W-1:0] OP_HALVE_U  = 3'd5;
   localparam logic [OP_W-1:0] OP_HALVE_V  = 3'd6;
   localparam logic [OP_W-1:0] OP_SUB      = 3'd7;

   // jump conditions
   localparam logic [COND_W-1:0] CD_NEVER    = 4'd0;
   localparam logic [COND_W-1:0] CD_REQ_IDLE = 4'd1;
   localparam logic [COND_W-1:0] CD_M_EVEN   = 4'd2;
   localparam logic [COND_W-1:0] CD_CNT_NZ   = 4'd3;
   localparam logic [COND_W-1:0] CD_V_ZERO   = 4'd4;
   localparam logic [COND_W-1:0] CD_U_EVEN   = 4'd5;
   localparam logic [COND_W-1:0] CD_V_EVEN   = 4'd6;
   localparam logic [COND_W-1:0] CD_U_NE_V   = 4'd7;
   localparam logic [COND_W-1:0] CD_V_NE_ONE = 4'd8;
   localparam logic [COND_W-1:0] CD_RSP_BUSY = 4'd9;

   // program addresses
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] PC_CHECK    = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV      = 4'd2;
   localparam logic [PC_W-1:0] PC_INIT     = 4'd3;
   localparam logic [PC_W-1:0] PC_HALVE_U  = 4'd4;
   localparam logic [PC_W-1:0] PC_HALVE_V  = 4'd5;
   localparam logic [PC_W-1:0] PC_SUB      = 4'd6;
   localparam logic [PC_W-1:0] PC_TEST     = 4'd7;
   localparam logic [PC_W-1:0] PC_POST_OK  = 4'd8;
   localparam logic [PC_W-1:0] PC_POST_EVN = 4'd9;
   localparam logic [PC_W-1:0] PC_POST_ZRO = 4'd10;
   localparam logic [PC_W-1:0] PC_POST_NOI = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                post;
      logic [STATUS_W-1:0] status;
      logic [COND_W-1:0]   cond;
      logic [PC_W-1:0]     target;
      logic [PC_W-1:0]     next;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic m_even;
      logic cnt_nz;
      logic v_zero;
      logic u_even;
      logic v_even;
      logic u_ne_v;
      logic v_ne_one;
      logic rsp_busy;
   } flags_type;

   function automatic ctl_type mk(input logic [OP_W-1:0] op, input logic post,
                                  input logic [STATUS_W-1:0] status,
                                  input logic [COND_W-1:0] cond,
                                  input logic [PC_W-1:0] target,
                                  input logic [PC_W-1:0] next);
      ctl_type w;
      w.op     = op;
      w.post   = post;
      w.status = status;
      w.cond   = cond;
      w.target = target;
      w.next   = next;
      return w;
   endfunction

   // microprogram: jump to target when cond holds, else go to next
   function automatic ctl_type rom_word(input logic [PC_W-1:0] pc);
      ctl_type w;
      unique case (pc)
         PC_IDLE:     w = mk(OP_LOAD, 1'b0, ST_OK, CD_REQ_IDLE, PC_IDLE, PC_CHECK);
         PC_CHECK:    w = mk(OP_DIV_INIT, 1'b0, ST_OK, CD_M_EVEN, PC_POST_EVN, PC_DIV);
         PC_DIV:      w = mk(OP_DIV_STEP, 1'b0, ST_OK, CD_CNT_NZ, PC_DIV, PC_INIT);
         PC_INIT:     w = mk(OP_EUC_INIT, 1'b0, ST_OK, CD_V_ZERO, PC_POST_ZRO, PC_HALVE_U);
         PC_HALVE_U:  w = mk(OP_HALVE_U, 1'b0, ST_OK, CD_U_EVEN, PC_HALVE_U, PC_HALVE_V);
         PC_HALVE_V:  w = mk(OP_HALVE_V, 1'b0, ST_OK, CD_V_EVEN, PC_HALVE_V, PC_SUB);
         PC_SUB:      w = mk(OP_SUB, 1'b0, ST_OK, CD_U_NE_V, PC_HALVE_U, PC_TEST);
         PC_TEST:     w = mk(OP_NOP, 1'b0, ST_OK, CD_V_NE_ONE, PC_POST_NOI, PC_POST_OK);
         PC_POST_OK:  w = mk(OP_NOP, 1'b1, ST_OK, CD_RSP_BUSY, PC_POST_OK, PC_IDLE);
         PC_POST_EVN: w = mk(OP_NOP, 1'b1, ST_EVEN_MOD, CD_RSP_BUSY, PC_POST_EVN, PC_IDLE);
         PC_POST_ZRO: w = mk(OP_NOP, 1'b1, ST_ZERO_VAL, CD_RSP_BUSY, PC_POST_ZRO, PC_IDLE);
         PC_POST_NOI: w = mk(OP_NOP, 1'b1, ST_NO_INV, CD_RSP_BUSY, PC_POST_NOI, PC_IDLE);
         default:     w = mk(OP_NOP, 1'b0, ST_OK, CD_NEVER, PC_IDLE, PC_IDLE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bmi_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmi_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmi_pkg::FIELD_W-1:0]  value;
   logic [bmi_pkg::FIELD_W-1:0]  modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink   (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmi_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bmi_pkg::FIELD_W-1:0]  inverse;
   logic [bmi_pkg::STATUS_W-1:0] status;

   modport source (output valid, output inverse, output status, input ready);
   modport sink   (input valid, input inverse, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmi_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmi_seq (
   input  wire                 clock,
   input  wire                 reset,
   input  bmi_pkg::flags_type  flags,
   output bmi_pkg::ctl_type    ctl
);

   logic [bmi_pkg::PC_W-1:0] pc_ff;
   logic [bmi_pkg::PC_W-1:0] pc_in;
   logic                     jump;

   assign ctl = bmi_pkg::rom_word(pc_ff);

   always_comb begin
      unique case (ctl.cond)
         bmi_pkg::CD_REQ_IDLE: jump = !flags.req_valid;
         bmi_pkg::CD_M_EVEN:   jump = flags.m_even;
         bmi_pkg::CD_CNT_NZ:   jump = flags.cnt_nz;
         bmi_pkg::CD_V_ZERO:   jump = flags.v_zero;
         bmi_pkg::CD_U_EVEN:   jump = flags.u_even;
         bmi_pkg::CD_V_EVEN:   jump = flags.v_even;
         bmi_pkg::CD_U_NE_V:   jump = flags.u_ne_v;
         bmi_pkg::CD_V_NE_ONE: jump = flags.v_ne_one;
         bmi_pkg::CD_RSP_BUSY: jump = flags.rsp_busy;
         default:              jump = 1'b0;
      endcase
      pc_in = jump ? ctl.target : ctl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bmi_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bmi_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmi_dp #(
   parameter int WIDTH = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  bmi_pkg::ctl_type    ctl,
   output bmi_pkg::flags_type  flags,
   bmi_req_if.sink             req_chan,
   bmi_rsp_if.source           rsp_chan
);

   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] m_ff, a_ff, v_ff, u_ff, cb_ff, cd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic [bmi_pkg::FIELD_W-1:0]  inverse_ff;
   logic [bmi_pkg::STATUS_W-1:0] status_ff;

   logic             take, busy, post;
   logic [WIDTH:0]   div_t, div_d;
   logic [WIDTH:0]   uv_d;
   logic [WIDTH-1:0] half_cb, half_cd;
   logic [WIDTH:0]   cbd_d, cdb_d;
   logic [WIDTH-1:0] cbd_mod, cdb_mod;

   assign take = req_chan.valid && req_chan.ready;
   assign busy = rsp_valid_ff && !rsp_chan.ready;
   assign post = ctl.post && !busy;

   assign req_chan.ready   = (ctl.op == bmi_pkg::OP_LOAD) && !reset;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.inverse = inverse_ff;
   assign rsp_chan.status  = status_ff;

   always_comb begin
      // restoring division step: shift in next dividend bit
      div_t = {v_ff, a_ff[WIDTH-1]};
      div_d = div_t - {1'b0, m_ff};
      uv_d  = {1'b0, u_ff} - {1'b0, v_ff};
      // halving modulo odd m
      half_cb = cb_ff[0] ? (cb_ff >> 1) + (m_ff >> 1) + WIDTH'(1) : cb_ff >> 1;
      half_cd = cd_ff[0] ? (cd_ff >> 1) + (m_ff >> 1) + WIDTH'(1) : cd_ff >> 1;
      // modular subtraction of cofactors
      cbd_d   = {1'b0, cb_ff} - {1'b0, cd_ff};
      cdb_d   = {1'b0, cd_ff} - {1'b0, cb_ff};
      cbd_mod = cbd_d[WIDTH] ? cbd_d[WIDTH-1:0] + m_ff : cbd_d[WIDTH-1:0];
      cdb_mod = cdb_d[WIDTH] ? cdb_d[WIDTH-1:0] + m_ff : cdb_d[WIDTH-1:0];
   end

   always_comb begin
      flags.req_valid = req_chan.valid;
      flags.m_even    = !m_ff[0];
      flags.cnt_nz    = (cnt_ff != '0);
      flags.v_zero    = (v_ff == '0);
      flags.u_even    = !u_ff[0];
      flags.v_even    = !v_ff[0];
      flags.u_ne_v    = (u_ff != v_ff);
      flags.v_ne_one  = (v_ff != WIDTH'(1));
      flags.rsp_busy  = busy;
   end

   always_ff @(posedge clock) begin
      unique case (ctl.op)
         bmi_pkg::OP_LOAD: begin
            if (take) begin
               a_ff <= req_chan.value[WIDTH-1:0];
               m_ff <= req_chan.modulus[WIDTH-1:0];
            end
         end
         bmi_pkg::OP_DIV_INIT: begin
            v_ff   <= '0;
            cnt_ff <= CNT_W'(WIDTH - 1);
         end
         bmi_pkg::OP_DIV_STEP: begin
            v_ff   <= div_d[WIDTH] ? div_t[WIDTH-1:0] : div_d[WIDTH-1:0];
            a_ff   <= a_ff << 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         bmi_pkg::OP_EUC_INIT: begin
            u_ff  <= m_ff;
            cb_ff <= '0;
            cd_ff <= WIDTH'(1);
         end
         bmi_pkg::OP_HALVE_U: begin
            if (!u_ff[0]) begin
               u_ff  <= u_ff >> 1;
               cb_ff <= half_cb;
            end
         end
         bmi_pkg::OP_HALVE_V: begin
            if (!v_ff[0]) begin
               v_ff  <= v_ff >> 1;
               cd_ff <= half_cd;
            end
         end
         bmi_pkg::OP_SUB: begin
            if (!uv_d[WIDTH]) begin
               u_ff  <= uv_d[WIDTH-1:0];
               cb_ff <= cbd_mod;
            end else begin
               v_ff  <= v_ff - u_ff;
               cd_ff <= cdb_mod;
            end
         end
         default: begin
         end
      endcase
      if (post) begin
         inverse_ff <= (ctl.status == bmi_pkg::ST_OK) ? bmi_pkg::FIELD_W'(cd_ff) : '0;
         status_ff  <= ctl.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/binary_modular_inverse_odd.sv =====
// Sequence: load the beat, check the modulus, run the restoring division steps, set up,
// then loop over passes of halving u, halving v and subtracting, then test and post;
// an even modulus is posted straight after the check.
// Throughput: one item at a time; the microprogram sequencer and its single datapath
// set the rate. The next beat is taken while the previous result waits in its register.
// Reset: synchronous, clears the program counter to idle and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module binary_modular_inverse_odd #(
   parameter int WIDTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   bmi_req_if.sink    req_chan,
   bmi_rsp_if.source  rsp_chan
);

   bmi_pkg::ctl_type   ctl;
   bmi_pkg::flags_type flags;

   bmi_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   bmi_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .flags    (flags),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bmi_pkg::*;

   localparam int WIDTH = 64;
   localparam int PHASE_ITEMS = 560;

   typedef struct {
      logic [FIELD_W-1:0]  inverse;
      logic [STATUS_W-1:0] status;
   } inv_result_t;

   class inverse_scoreboard;
      inv_result_t pending_inverses[$];
      int          errors;
      int          requests;
      int          responses;
      int          status_seen[4];

      function bit [63:0] halve_mod(bit [63:0] r, bit [63:0] m);
         if (!r[0]) return r >> 1;
         return (r >> 1) + (m >> 1) + 64'd1;
      endfunction

      function bit [63:0] sub_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
         if (a >= b) return a - b;
         return a + (m - b);
      endfunction

      // binary extended Euclid with cofactors kept as residues mod m
      function inv_result_t predict_inverse(bit [63:0] value_in, bit [63:0] modulus_in);
         bit [63:0]   mask;
         bit [63:0]   m;
         bit [63:0]   u;
         bit [63:0]   v;
         bit [63:0]   cb;
         bit [63:0]   cd;
         inv_result_t r;
         mask = ~64'd0 >> (64 - WIDTH);
         m = modulus_in & mask;
         r.inverse = '0;
         if (!m[0]) begin
            r.status = ST_EVEN_MOD;
            return r;
         end
         v = (value_in & mask) % m;
         if (v == 0) begin
            r.status = ST_ZERO_VAL;
            return r;
         end
         u = m;
         cb = 64'd0;
         cd = 64'd1;
         do begin
            while (!u[0]) begin
               u = u >> 1;
               cb = halve_mod(cb, m);
            end
            while (!v[0]) begin
               v = v >> 1;
               cd = halve_mod(cd, m);
            end
            if (u >= v) begin
               u = u - v;
               cb = sub_mod(cb, cd, m);
            end else begin
               v = v - u;
               cd = sub_mod(cd, cb, m);
            end
         end while (u != 0);
         if (v != 64'd1) begin
            r.status = ST_NO_INV;
            return r;
         end
         r.inverse = cd & mask;
         r.status = ST_OK;
         return r;
      endfunction

      function void note_request(bit [63:0] value_in, bit [63:0] modulus_in);
         pending_inverses.push_back(predict_inverse(value_in, modulus_in));
         requests++;
      endfunction

      function void check_response(logic [FIELD_W-1:0] inverse, logic [STATUS_W-1:0] status);
         inv_result_t want;
         responses++;
         if (pending_inverses.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat inverse %h status %0d", $time, inverse, status);
            return;
         end
         want = pending_inverses.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (inverse !== want.inverse) begin
            errors++;
            $display("%0t: inverse expected %h actual %h", $time, want.inverse, inverse);
         end
         status_seen[want.status]++;
      endfunction

      function int outstanding();
         return pending_inverses.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   bmi_req_if req_chan();
   bmi_rsp_if rsp_chan();

   binary_modular_inverse_odd #(.WIDTH(WIDTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   inverse_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("binary_modular_inverse_odd: mismatch");
      $finish;
   end

   // receiver: random backpressure plus an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.inverse, rsp_chan.status);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic bit [63:0] rand_bits(int n);
      bit [63:0] r;
      r = {$urandom, $urandom};
      if (n < 64) r &= (64'd1 << n) - 64'd1;
      return r;
   endfunction

   task automatic send_beat(bit [63:0] value_in, bit [63:0] modulus_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.value   <= value_in;
      req_chan.modulus <= modulus_in;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(value_in, modulus_in);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_random_beat();
      bit [63:0] val;
      bit [63:0] m;
      bit [63:0] g;
      int        pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         m = rand_bits($urandom_range(1, 64)) & ~64'd1;
         val = rand_bits(64);
      end else if (pick < 16) begin
         // value a multiple of the modulus
         m = rand_bits($urandom_range(1, 60)) | 64'd1;
         val = m * $urandom_range(0, 15);
      end else if (pick < 32) begin
         // shared odd factor
         g = 2 * $urandom_range(1, 20) + 1;
         m = g * (rand_bits($urandom_range(1, 58)) | 64'd1);
         val = g * rand_bits($urandom_range(1, 58));
      end else begin
         m = rand_bits($urandom_range(1, 64)) | 64'd1;
         val = ($urandom_range(1) == 1) ? rand_bits(64) : rand_bits($urandom_range(1, 64));
      end
      send_beat(val, m);
   endtask

   task automatic run_phase(int count, int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_random_beat();
      wait_drained();
   endtask

   initial begin
      bit [63:0] all_ones;
      sb = new();
      all_ones = ~64'd0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      rsp_hold_cycles = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.modulus = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 21;
      recv_idle_pct = 72;
      send_beat(64'd0, 64'd0);
      send_beat(all_ones, 64'd0);
      send_beat(64'd1, 64'd2);
      send_beat(all_ones, all_ones - 64'd1);
      send_beat(64'd3, 64'd1);
      send_beat(64'd0, 64'd1);
      send_beat(64'd0, 64'd7);
      send_beat(64'd14, 64'd7);
      send_beat(64'd1, 64'd3);
      send_beat(64'd2, 64'd3);
      send_beat(64'd6, 64'd9);
      send_beat(all_ones, all_ones);
      send_beat(all_ones - 64'd1, all_ones);
      send_beat(64'd1, all_ones);
      send_beat(all_ones, 64'd3);
      send_beat(64'h8000_0000_0000_0000, all_ones);
      send_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
      send_beat(64'd12345, 64'd1_000_000_007);
      send_beat(64'd100, 64'd7);
      send_beat(64'd3, 64'h8000_0000_0000_0001);
      send_beat(all_ones, 64'hFFFF_FFFF_FFFF_FFC5);
      send_beat(64'hFFFF_FFFF_FFFF_FFC4, 64'hFFFF_FFFF_FFFF_FFC5);
      wait_drained();

      run_phase(PHASE_ITEMS, 21, 72);
      run_phase(PHASE_ITEMS, 72, 21);
      // long receiver stall while the sender keeps pushing
      rsp_hold_cycles = 2000;
      run_phase(PHASE_ITEMS, 0, 0);

      repeat (1200) @(posedge clock);
      $display("covered %0d requests and %0d responses under idle, stall and back-to-back",
               sb.requests, sb.responses);
      $display("statuses seen: ok %0d, even modulus %0d, zero value %0d, no inverse %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_EVEN_MOD],
               sb.status_seen[ST_ZERO_VAL], sb.status_seen[ST_NO_INV]);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("binary_modular_inverse_odd: match");
      end else begin
         $display("binary_modular_inverse_odd: mismatch");
      end
      $finish;
   end

endmodule
